// ----- rtl/core/a64lsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64lsu_pkg: shared types and constants of the load/store unit
// Status codes, instruction field constants and the structs that pass
// between the decoder, the banked data memory and the top level.
// ----------------------------------------------------------------------------
package a64lsu_pkg;

   localparam longint unsigned MEM_BYTES_DEF = 64'd65536;

   localparam int BANKS = 8;

   // op field
   localparam logic OP_TRANSFER = 1'b0;
   localparam logic OP_LITERAL  = 1'b1;

   // option bits [15:10] that select register offset
   localparam logic [5:0] REG_OFFSET_OPT = 6'd26;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BOUNDS = 2'd1,
      STATUS_MODE   = 2'd2
   } status_type;

   typedef struct packed {
      logic        op;
      logic [31:0] instruction;
      logic [31:0] pc;
      logic [63:0] base_value;
      logic [63:0] offset_value;
      logic [63:0] store_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] address;
      logic        wide;
      logic        load_write;
      logic        mem_write;
      logic [4:0]  target_reg;
      logic        base_write;
      logic [4:0]  base_reg;
      logic [63:0] base_new_value;
   } dec_type;

   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic        wide;
      logic [31:0] addr;
      logic [63:0] wdata;
   } mem_req_type;

endpackage

// ----- rtl/core/a64lsu_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64lsu_decode: addressing mode decode and bounds check
// Works out the effective address, the base update and the fault status
// of one instruction.
// ----------------------------------------------------------------------------
module a64lsu_decode #(
   parameter longint unsigned MEM_BYTES = a64lsu_pkg::MEM_BYTES_DEF
) (
   input  a64lsu_pkg::req_type req,
   output a64lsu_pkg::dec_type dec
);

   localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

   logic [31:0] insn;
   logic        wide;
   logic [63:0] simm9;
   logic [31:0] simm19x4;
   logic [31:0] scaled;
   logic [63:0] idx_sum;
   logic        indexed;
   logic        mode_ok;
   logic [31:0] addr;
   logic [32:0] addr_end;
   logic        in_bounds;
   logic        is_load;
   logic        commit;

   assign insn     = req.instruction;
   assign wide     = insn[30];
   assign simm9    = {{55{insn[20]}}, insn[20:12]};
   assign simm19x4 = {{11{insn[23]}}, insn[23:5], 2'b00};
   assign scaled   = wide ? {17'd0, insn[21:10], 3'b000} : {18'd0, insn[21:10], 2'b00};
   assign idx_sum  = req.base_value + simm9;
   assign indexed  = (req.op == a64lsu_pkg::OP_TRANSFER) && !insn[24]
                     && insn[10] && !insn[21];
   assign is_load  = (req.op == a64lsu_pkg::OP_LITERAL) || insn[22];

   always_comb begin
      mode_ok = 1'b1;
      if (req.op == a64lsu_pkg::OP_LITERAL) begin
         addr = req.pc + simm19x4;
      end else if (insn[24]) begin
         addr = req.base_value[31:0] + scaled;
      end else if (indexed) begin
         addr = insn[11] ? idx_sum[31:0] : req.base_value[31:0];
      end else if (insn[15:10] == a64lsu_pkg::REG_OFFSET_OPT && insn[21]) begin
         addr = req.base_value[31:0] + req.offset_value[31:0];
      end else begin
         addr    = 32'd0;
         mode_ok = 1'b0;
      end
   end

   assign addr_end  = {1'b0, addr} + (wide ? 33'd8 : 33'd4);
   assign in_bounds = addr_end <= MEM_LIMIT;
   assign commit    = mode_ok && in_bounds;

   always_comb begin
      if (!mode_ok) begin
         dec.status = a64lsu_pkg::STATUS_MODE;
      end else if (!in_bounds) begin
         dec.status = a64lsu_pkg::STATUS_BOUNDS;
      end else begin
         dec.status = a64lsu_pkg::STATUS_OK;
      end
      dec.address        = addr;
      dec.wide           = wide;
      dec.load_write     = commit && is_load;
      dec.mem_write      = commit && !is_load;
      dec.target_reg     = insn[4:0];
      dec.base_write     = commit && indexed;
      dec.base_reg       = (req.op == a64lsu_pkg::OP_LITERAL) ? 5'd0 : insn[9:5];
      dec.base_new_value = (commit && indexed) ? idx_sum : 64'd0;
   end

endmodule

// ----- rtl/core/a64lsu_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64lsu_mem: eight-bank byte memory
// Byte address a sits in bank a mod 8, row a / 8, so any 4 or 8 byte
// access, aligned or not, touches each bank at most once. Cleared row by row
// after reset.
// ----------------------------------------------------------------------------
module a64lsu_mem #(
   parameter longint unsigned MEM_BYTES = a64lsu_pkg::MEM_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  a64lsu_pkg::mem_req_type mem_req,
   output logic                    clear_busy,
   output logic [63:0]             rdata
);

   localparam longint unsigned ROWS = (MEM_BYTES + 64'd7) / 64'd8;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic          clearing_ff, clearing_in;
   logic [RW-1:0] clear_row_ff, clear_row_in;
   logic [RW-1:0] row;
   logic [2:0]    off;
   logic [2:0]    off_ff, off_in;
   logic          wide_ff, wide_in;
   logic [7:0]    rdata_ff [a64lsu_pkg::BANKS];

   assign row        = RW'(mem_req.addr[31:3]);
   assign off        = mem_req.addr[2:0];
   assign clear_busy = clearing_ff;

   // clearing pass, one row of every bank per cycle
   always_comb begin
      clearing_in  = clearing_ff;
      clear_row_in = clear_row_ff;
      if (clearing_ff) begin
         clear_row_in = clear_row_ff + RW'(1);
         if (clear_row_ff == RW'(ROWS - 64'd1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign off_in  = (mem_req.rd_en && !clearing_ff) ? off : off_ff;
   assign wide_in = (mem_req.rd_en && !clearing_ff) ? mem_req.wide : wide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_row_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_row_ff <= clear_row_in;
      end
      off_ff  <= off_in;
      wide_ff <= wide_in;
   end

   for (genvar b = 0; b < a64lsu_pkg::BANKS; b++) begin : g_bank
      logic [7:0]    bank_mem [ROWS];
      logic [2:0]    lane;
      logic [RW-1:0] bank_row;
      logic          bank_we;
      logic [RW-1:0] bank_wa;
      logic [7:0]    bank_wd;

      // byte lane of the access that lands in this bank
      assign lane     = 3'(b) - off;
      assign bank_row = (3'(b) < off) ? row + RW'(1) : row;
      assign bank_we  = clearing_ff || (mem_req.wr_en && (mem_req.wide || !lane[2]));
      assign bank_wa  = clearing_ff ? clear_row_ff : bank_row;
      assign bank_wd  = clearing_ff ? 8'd0 : mem_req.wdata[lane*8 +: 8];

      always_ff @(posedge clock) begin
         if (bank_we) begin
            bank_mem[bank_wa] <= bank_wd;
         end
         if (mem_req.rd_en && !clearing_ff) begin
            rdata_ff[b] <= bank_mem[bank_row];
         end
      end
   end

   // rotate banks back into byte order, zero-extend narrow loads
   always_comb begin
      logic [2:0] idx;
      for (int i = 0; i < a64lsu_pkg::BANKS; i++) begin
         idx = off_ff + 3'(i);
         rdata[i*8 +: 8] = rdata_ff[idx];
      end
      if (!wide_ff) begin
         rdata[63:32] = 32'd0;
      end
   end

endmodule

// ----- rtl/core/aarch64_load_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarch64_load_store_unit: AArch64 single data transfer load/store unit
// Pipeline: a result passes through three register stages, the first loaded
// at acceptance (input register, decoded/memory stage, result register).
// Throughput: one transaction per cycle unless the response side stalls; each
// data memory bank has one port, and an access uses each bank at most once.
// Reset: a clearing pass zeroes the memory, one row of all eight banks per
// cycle, ceil(MEM_BYTES / 8) rows (8192 by default); req_tready stays low.
// ----------------------------------------------------------------------------
module aarch64_load_store_unit #(
   parameter longint unsigned MEM_BYTES = a64lsu_pkg::MEM_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // instruction [31:0], pc [63:32], base_value [127:64],
   // offset_value [191:128], store_value [255:192]
   input  logic [255:0] req_tdata,
   // op [0]
   input  logic [0:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // address [31:0], load_write [32], target_reg [37:33], load_data [101:38],
   // base_write [102], base_reg [107:103], base_new_value [171:108],
   // zero pad [175:172]
   output logic [175:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]   rsp_tuser
);

   // Three register stages: input register, decoded/memory stage, result
   // register. Each stage moves on when the one after it is empty or moving,
   // so bubbles fill up while a result waits at the output.

   a64lsu_pkg::req_type     req_in, req_ff;
   logic                    v1_ff, v1_in;
   a64lsu_pkg::dec_type     dec;
   a64lsu_pkg::dec_type     dec_ff, dec_in;
   logic                    v2_ff, v2_in;
   a64lsu_pkg::mem_req_type mem_req;
   logic                    clear_busy;
   logic [63:0]             mem_rdata;
   logic                    vo_ff, vo_in;
   logic [175:0]            out_ff, out_in;
   logic [1:0]              status_ff, status_in;
   logic                    adv_out, adv2, adv1, accept;

   assign adv_out    = !vo_ff || rsp_tready;
   assign adv2       = !v2_ff || adv_out;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1 && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   // stage 1: input register
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.op           = req_tuser[0];
         req_in.instruction  = req_tdata[31:0];
         req_in.pc           = req_tdata[63:32];
         req_in.base_value   = req_tdata[127:64];
         req_in.offset_value = req_tdata[191:128];
         req_in.store_value  = req_tdata[255:192];
      end
   end
   assign v1_in = accept ? 1'b1 : (adv2 ? 1'b0 : v1_ff);

   a64lsu_decode #(
      .MEM_BYTES (MEM_BYTES)
   ) u_decode (
      .req (req_ff),
      .dec (dec)
   );

   // memory access issues as the transaction leaves stage 1
   always_comb begin
      mem_req.rd_en = v1_ff && adv2 && dec.load_write;
      mem_req.wr_en = v1_ff && adv2 && dec.mem_write;
      mem_req.wide  = dec.wide;
      mem_req.addr  = dec.address;
      mem_req.wdata = req_ff.store_value;
   end

   a64lsu_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .clear_busy (clear_busy),
      .rdata      (mem_rdata)
   );

   // stage 2: decoded fields, memory read data held in the banks
   assign dec_in = (v1_ff && adv2) ? dec : dec_ff;
   assign v2_in  = adv2 ? v1_ff : v2_ff;

   // result register
   always_comb begin
      out_in    = out_ff;
      status_in = status_ff;
      if (v2_ff && adv_out) begin
         status_in         = dec_ff.status;
         out_in[31:0]      = dec_ff.address;
         out_in[32]        = dec_ff.load_write;
         out_in[37:33]     = dec_ff.target_reg;
         out_in[101:38]    = dec_ff.load_write ? mem_rdata : 64'd0;
         out_in[102]       = dec_ff.base_write;
         out_in[107:103]   = dec_ff.base_reg;
         out_in[171:108]   = dec_ff.base_new_value;
         out_in[175:172]   = 4'd0;
      end
   end
   assign vo_in = adv_out ? v2_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         vo_ff <= vo_in;
      end
      req_ff    <= req_in;
      dec_ff    <= dec_in;
      out_ff    <= out_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = status_ff;

endmodule

// ----- test/tb_aarch64_load_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aarch64_load_store_unit: self-checking bench for the load/store unit
// Drives AArch64 load/store transactions through the request stream and
// predicts every response against a shadow copy of the data memory. A short
// directed sequence hits the address-mode edges, wrap-around and the memory
// bounds. Randomised traffic follows, mostly legal accesses into a small hot
// window so that loads see earlier stores, under several idle/stall phases.
// ----------------------------------------------------------------------------
module tb_aarch64_load_store_unit;

   localparam longint unsigned MEM_SIZE = a64lsu_pkg::MEM_BYTES_DEF;
   // the post-reset clearing pass zeroes MEM_SIZE/8 rows with no acceptance
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int PHASE_ITEMS    = 250;
   localparam int TAIL_CYCLES    = 16;

   // one response transaction, unpacked
   typedef struct packed {
      a64lsu_pkg::status_type status;
      logic [31:0]            address;
      logic                   load_write;
      logic [4:0]             target_reg;
      logic [63:0]            load_data;
      logic                   base_write;
      logic [4:0]             base_reg;
      logic [63:0]            base_new_value;
   } lsu_result_type;

   // Shadow memory plus the queue of responses still owed by the unit
   class lsu_scoreboard;
      logic [7:0]     shadow_mem [0:MEM_SIZE-1];
      lsu_result_type awaited_results [$];
      int             errors;

      function new();
         foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
         errors = 0;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // Execute one accepted request against the shadow memory
      function void note_request(logic op, logic [31:0] insn, logic [31:0] pc,
                                 logic [63:0] base, logic [63:0] offv,
                                 logic [63:0] sval);
         lsu_result_type r;
         logic [63:0] s9;
         logic [63:0] s19;
         logic [63:0] ea;
         logic [31:0] addr;
         int          nbytes;
         bit          legal;
         bit          is_load;
         r          = '0;
         r.status   = a64lsu_pkg::STATUS_OK;
         r.target_reg = insn[4:0];
         nbytes     = insn[30] ? 8 : 4;
         legal      = 1'b1;
         if (op == a64lsu_pkg::OP_LITERAL) begin
            s19     = {{45{insn[23]}}, insn[23:5]};
            ea      = {32'd0, pc} + (s19 << 2);
            is_load = 1'b1;
         end else begin
            s9         = {{55{insn[20]}}, insn[20:12]};
            r.base_reg = insn[9:5];
            is_load    = insn[22];
            ea         = '0;
            if (insn[24]) begin
               ea = base + ({52'd0, insn[21:10]} << (insn[30] ? 3 : 2));
            end else if (insn[10] && !insn[21]) begin
               r.base_new_value = base + s9;
               r.base_write     = 1'b1;
               ea = insn[11] ? r.base_new_value : base;
            end else if (insn[15:10] == a64lsu_pkg::REG_OFFSET_OPT && insn[21]) begin
               ea = base + offv;
            end else begin
               legal = 1'b0;
            end
         end
         addr = ea[31:0];

         if (!legal) begin
            r.status         = a64lsu_pkg::STATUS_MODE;
            r.base_write     = 1'b0;
            r.base_new_value = '0;
         end else if ({32'd0, addr} + 64'(nbytes) > MEM_SIZE) begin
            r.status         = a64lsu_pkg::STATUS_BOUNDS;
            r.address        = addr;
            r.base_write     = 1'b0;
            r.base_new_value = '0;
         end else begin
            r.address = addr;
            if (is_load) begin
               for (int i = 0; i < nbytes; i++)
                  r.load_data[8*i +: 8] = shadow_mem[addr + i];
               r.load_write = 1'b1;
            end else begin
               for (int i = 0; i < nbytes; i++)
                  shadow_mem[addr + i] = sval[8*i +: 8];
            end
         end
         awaited_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void check_result(lsu_result_type got);
         lsu_result_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: response with none outstanding, expected nothing, got %h",
                     $time, got);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("status",         64'(want.status),     64'(got.status));
         compare_field("address",        64'(want.address),    64'(got.address));
         compare_field("load_write",     64'(want.load_write), 64'(got.load_write));
         compare_field("target_reg",     64'(want.target_reg), 64'(got.target_reg));
         compare_field("load_data",      want.load_data,       got.load_data);
         compare_field("base_write",     64'(want.base_write), 64'(got.base_write));
         compare_field("base_reg",       64'(want.base_reg),   64'(got.base_reg));
         compare_field("base_new_value", want.base_new_value,  got.base_new_value);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;    // instruction, pc, base_value, offset_value, store_value
   logic [0:0]   req_tuser;    // op
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [175:0] rsp_tdata;    // address, load_write, target_reg, load_data,
                               // base_write, base_reg, base_new_value, pad
   logic [1:0]   rsp_tuser;    // status

   lsu_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   aarch64_load_store_unit #(
      .MEM_BYTES (MEM_SIZE)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver back-pressure: a fresh decision at every falling edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: both handshakes are sampled at the rising edge. Requests are
   // noted before responses are checked, so the ordering within the edge
   // never matters. The watchdog also lives here.
   always @(posedge clock) begin
      lsu_result_type seen;
      bit             moved;
      moved = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         sb.note_request(req_tuser[0], req_tdata[31:0], req_tdata[63:32],
                         req_tdata[127:64], req_tdata[191:128], req_tdata[255:192]);
         moved = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status         = a64lsu_pkg::status_type'(rsp_tuser);
         seen.address        = rsp_tdata[31:0];
         seen.load_write     = rsp_tdata[32];
         seen.target_reg     = rsp_tdata[37:33];
         seen.load_data      = rsp_tdata[101:38];
         seen.base_write     = rsp_tdata[102];
         seen.base_reg       = rsp_tdata[107:103];
         seen.base_new_value = rsp_tdata[171:108];
         sb.check_result(seen);
         moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_aarch64_load_store_unit: done, errors");
         $finish;
      end
   end

   // Instruction encoders for the directed part
   function automatic logic [31:0] enc_uimm(logic [4:0] rt, logic [4:0] xn,
                                            logic [11:0] imm12, logic load, logic wide);
      logic [31:0] w;
      w = '0;
      w[4:0]   = rt;
      w[9:5]   = xn;
      w[21:10] = imm12;
      w[22]    = load;
      w[24]    = 1'b1;
      w[30]    = wide;
      return w;
   endfunction

   function automatic logic [31:0] enc_indexed(logic [4:0] rt, logic [4:0] xn,
                                               logic [8:0] simm9, logic pre,
                                               logic load, logic wide);
      logic [31:0] w;
      w = '0;
      w[4:0]   = rt;
      w[9:5]   = xn;
      w[10]    = 1'b1;
      w[11]    = pre;
      w[20:12] = simm9;
      w[22]    = load;
      w[30]    = wide;
      return w;
   endfunction

   function automatic logic [31:0] enc_regoff(logic [4:0] rt, logic [4:0] xn,
                                              logic [4:0] xm, logic load, logic wide);
      logic [31:0] w;
      w = '0;
      w[4:0]   = rt;
      w[9:5]   = xn;
      w[15:10] = a64lsu_pkg::REG_OFFSET_OPT;
      w[20:16] = xm;
      w[21]    = 1'b1;
      w[22]    = load;
      w[30]    = wide;
      return w;
   endfunction

   function automatic logic [31:0] enc_literal(logic [4:0] rt, logic [18:0] simm19,
                                               logic wide);
      logic [31:0] w;
      w = '0;
      w[4:0]  = rt;
      w[23:5] = simm19;
      w[30]   = wide;
      return w;
   endfunction

   // Target address: mostly a small hot window so loads hit earlier stores,
   // then anywhere in memory, the top edge, and arbitrary 32-bit addresses.
   function automatic logic [31:0] pick_address();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55)
         return $urandom_range(63);
      if (r < 75)
         return $urandom_range(32'(MEM_SIZE - 8));
      if (r < 90)
         return 32'(MEM_SIZE - 12) + $urandom_range(15);
      return $urandom;
   endfunction

   // Present one transaction and hold it until accepted. Called at a falling
   // edge; returns at the falling edge after acceptance with tvalid still
   // high, so back-to-back transactions never drop it.
   task automatic send_request(input logic op, input logic [31:0] insn,
                               input logic [31:0] pc, input logic [63:0] base,
                               input logic [63:0] offv, input logic [63:0] sval);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sval, offv, base, pc, insn};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding response has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // One random transaction; register values are back-solved from the chosen
   // target so that wrapped bases and offsets still land where intended.
   task automatic send_random();
      int unsigned pick;
      logic        op;
      logic [31:0] insn;
      logic [31:0] pc;
      logic [31:0] target;
      logic [63:0] base;
      logic [63:0] offv;
      logic [63:0] sval;
      logic [31:0] s9;
      op     = a64lsu_pkg::OP_TRANSFER;
      insn   = $urandom;
      pc     = $urandom;
      offv   = {$urandom, $urandom};
      sval   = {$urandom, $urandom};
      base   = {$urandom, $urandom};
      target = pick_address();
      pick   = $urandom_range(99);
      if (pick < 25) begin
         // unsigned scaled immediate
         insn[24]   = 1'b1;
         base[31:0] = target - ({20'd0, insn[21:10]} << (insn[30] ? 3 : 2));
      end else if (pick < 55) begin
         // pre/post-indexed
         insn[24]   = 1'b0;
         insn[21]   = 1'b0;
         insn[10]   = 1'b1;
         s9         = {{23{insn[20]}}, insn[20:12]};
         base[31:0] = insn[11] ? target - s9 : target;
      end else if (pick < 75) begin
         // register offset
         insn[24]    = 1'b0;
         insn[21]    = 1'b1;
         insn[15:10] = a64lsu_pkg::REG_OFFSET_OPT;
         base[31:0]  = target - offv[31:0];
      end else if (pick < 90) begin
         op = a64lsu_pkg::OP_LITERAL;
         pc = target - {{11{insn[23]}}, insn[23:5], 2'b00};
      end else begin
         // undecodable: U clear and neither indexed nor register offset
         do begin
            insn     = $urandom;
            insn[24] = 1'b0;
         end while ((insn[10] && !insn[21]) ||
                    (insn[15:10] == a64lsu_pkg::REG_OFFSET_OPT && insn[21]));
      end
      send_request(op, insn, pc, base, offv, sval);
   endtask

   int phase_send_pct [5] = '{0, 49, 0, 19, 0};
   int phase_recv_pct [5] = '{0, 0, 49, 19, 0};

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // load from freshly cleared memory
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd1, 5'd2, 12'd0, 1'b1, 1'b1),
                   32'd0, 64'd0, 64'd0, 64'd0);
      // wide store at 0, narrow unaligned store overlapping it, read back
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd3, 5'd4, 12'd0, 1'b0, 1'b1),
                   32'd0, 64'd0, 64'd0, 64'h0123_4567_89AB_CDEF);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd5, 5'd6, 12'd0, 1'b0, 1'b0),
                   32'd0, 64'd5, 64'd0, 64'hFFFF_FFFF_A5A5_5A5A);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd7, 5'd8, 12'd0, 1'b1, 1'b1),
                   32'd0, 64'd0, 64'd0, 64'd0);
      // narrow load is zero-extended
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd9, 5'd10, 12'd0, 1'b1, 1'b0),
                   32'd0, 64'd3, 64'd0, 64'd0);
      // largest scaled immediate, upper base bits dropped from the address
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_uimm(5'd31, 5'd31, 12'hFFF, 1'b0, 1'b1), 32'd0,
                   64'hFFFF_FFFF_0000_0000, 64'd0, '1);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd0, 5'd0, 12'hFFF, 1'b1, 1'b0),
                   32'd0, 64'h100, 64'd0, 64'd0);
      // pre-index with the most negative offset
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_indexed(5'd11, 5'd12, 9'h100, 1'b1, 1'b1, 1'b1),
                   32'd0, 64'h108, 64'd0, 64'd0);
      // post-index store with the most positive offset
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_indexed(5'd13, 5'd14, 9'h0FF, 1'b0, 1'b0, 1'b1),
                   32'd0, 64'd16, 64'd0, 64'hDEAD_BEEF_CAFE_F00D);
      // pre-index runs below zero: out of bounds, base update suppressed
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_indexed(5'd15, 5'd16, 9'h1FF, 1'b1, 1'b1, 1'b0),
                   32'd0, 64'd0, 64'd0, 64'd0);
      // post-index base update wraps at 64 bits while the access is legal
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_indexed(5'd17, 5'd18, 9'h100, 1'b0, 1'b1, 1'b1),
                   32'd0, 64'h10, 64'd0, 64'd0);
      // Rt equal to Xn with both writes flagged
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_indexed(5'd7, 5'd7, 9'h000, 1'b1, 1'b1, 1'b1),
                   32'd0, 64'h10, 64'd0, 64'd0);
      // register offset, sum wraps at 64 bits
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_regoff(5'd19, 5'd20, 5'd21, 1'b1, 1'b1), 32'd0,
                   64'h0000_0001_0000_0020, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0);
      send_request(a64lsu_pkg::OP_TRANSFER,
                   enc_regoff(5'd22, 5'd23, 5'd31, 1'b0, 1'b0), 32'd0,
                   64'h40, 64'd0, 64'h5555_5555_1234_5678);
      // undecodable modes
      send_request(a64lsu_pkg::OP_TRANSFER, 32'h0000_0000, 32'd0, 64'd0, 64'd0, 64'd0);
      send_request(a64lsu_pkg::OP_TRANSFER, 32'h0000_6800, 32'd0, 64'd0, 64'd0, 64'd0);
      send_request(a64lsu_pkg::OP_TRANSFER, 32'hFEFF_FFFF, '1, '1, '1, '1);
      // load literal, negative displacement and wrap at 32 bits
      send_request(a64lsu_pkg::OP_LITERAL, enc_literal(5'd24, 19'h7FFC0, 1'b1),
                   32'h100, '1, '1, '1);
      send_request(a64lsu_pkg::OP_LITERAL, enc_literal(5'd25, 19'h00008, 1'b0),
                   32'hFFFF_FFF0, 64'd0, 64'd0, 64'd0);
      // bounds: last legal and first illegal address for each size
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd1, 5'd1, 12'd0, 1'b1, 1'b0),
                   32'd0, 64'(MEM_SIZE - 4), 64'd0, 64'd0);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd1, 5'd1, 12'd0, 1'b1, 1'b0),
                   32'd0, 64'(MEM_SIZE - 3), 64'd0, 64'd0);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd2, 5'd2, 12'd0, 1'b0, 1'b1),
                   32'd0, 64'(MEM_SIZE - 8), 64'd0, 64'h8877_6655_4433_2211);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd2, 5'd2, 12'd0, 1'b0, 1'b1),
                   32'd0, 64'(MEM_SIZE - 7), 64'd0, '1);
      send_request(a64lsu_pkg::OP_TRANSFER, enc_uimm(5'd3, 5'd3, 12'd0, 1'b1, 1'b1),
                   32'd0, 64'(MEM_SIZE - 8), 64'd0, 64'd0);
      send_request(a64lsu_pkg::OP_LITERAL, enc_literal(5'd26, 19'h00000, 1'b0),
                   32'(MEM_SIZE), 64'd0, 64'd0, 64'd0);
      wait_for_results();

      // --- random, one idling profile per phase ---
      for (int p = 0; p < 5; p++) begin
         send_idle_pct  = phase_send_pct[p];
         recv_stall_pct = phase_recv_pct[p];
         repeat (PHASE_ITEMS) send_random();
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0)
         $display("tb_aarch64_load_store_unit: done, clean");
      else
         $display("tb_aarch64_load_store_unit: done, errors");
      $finish;
   end

endmodule

// ----- aarch64_load_store_unit.f -----
rtl/core/a64lsu_pkg.sv
rtl/core/a64lsu_decode.sv
rtl/core/a64lsu_mem.sv
rtl/core/aarch64_load_store_unit.sv
test/tb_aarch64_load_store_unit.sv
